@@ src/pdstore_pkg.sv @@
// Package for the two-bank packet descriptor store.
// Holds the channel item types, the stored descriptor layout and default sizes.
// No dependencies.
`default_nettype none

package pdstore_pkg;

  localparam int unsigned DEF_PACKETS_PER_BANK = 1024;
  localparam int unsigned DEF_BYTES_PER_BANK   = 65536;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] packet_size;
    logic        is_receive;
    logic        has_compartment;
    logic        has_header_size;
    logic        has_interface;
    logic        has_subinterface;
    logic [31:0] compartment;
    logic [31:0] interface_index;
    logic [31:0] subinterface_index;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        bank;
    logic [15:0] data_offset;
    logic [15:0] out_size;
    logic        out_receive;
    logic [31:0] out_compartment;
    logic [31:0] out_interface;
    logic [31:0] out_subinterface;
    logic [10:0] dropped_count;
    logic        store_empty;
  } out_item_t;

  // One descriptor entry; the data offset is kept so a pop needs no running sum.
  typedef struct packed {
    logic [15:0] size;
    logic        receive;
    logic [31:0] compartment;
    logic [31:0] if_idx;
    logic [31:0] sub_idx;
    logic [15:0] offset;
  } desc_t;

  // Control and status of an item between the state update and the result register.
  typedef struct packed {
    logic        is_pop;
    logic        ok;
    logic        bank;
    logic [15:0] offset;
    logic [10:0] dropped;
    logic        empty;
  } stage_t;

endpackage

`default_nettype wire

@@ src/pdstore_chan_if.sv @@
// Valid/ready channel used for the input and result items of the descriptor store.
// The payload type is set per instance; no other dependencies.
`default_nettype none

interface pdstore_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/two_bank_packet_descriptor_store_top.sv @@
// Two-bank (ping-pong) packet descriptor store, top level.
// Depends on pdstore_pkg and the pdstore_chan_if channel interface.
//
// Usage:
//   in_ch  carries one request item: a push (store a descriptor) or a pop
//          (return the oldest unread descriptor). Accepted on valid && ready.
//   out_ch carries exactly one result item per request, in request order.
//   A request's state update and memory access happen at acceptance; its
//   result then passes the middle stage and the result register.
//   Throughput: one item per cycle while out_ch does not stall; pointers and
//   bank counts update in the cycle of acceptance, and the descriptor memory
//   takes one write (push) or one registered read (pop) per cycle.
//   When the receiver stalls, the finished result holds in the output
//   register and one more item can wait in the middle stage; in_ch.ready
//   drops only when both are occupied.
//   Reset (rst_n low, synchronous) empties both banks and clears the pointers.
//   The descriptor memory is not cleared: entries are only read after they
//   have been written, so no clearing pass is needed.
//   A push that finds its bank full by count or by bytes moves to the other
//   bank and reports the descriptors it overwrites there as dropped.
`default_nettype none

module two_bank_packet_descriptor_store_top #(
  parameter int unsigned PACKETS_PER_BANK = pdstore_pkg::DEF_PACKETS_PER_BANK,
  parameter int unsigned BYTES_PER_BANK   = pdstore_pkg::DEF_BYTES_PER_BANK
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  pdstore_chan_if.sink   in_ch,
  pdstore_chan_if.source out_ch
);

  localparam int unsigned DEPTH = 2 * PACKETS_PER_BANK;
  localparam int unsigned CW    = $clog2(PACKETS_PER_BANK + 1);  // bank count width
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW    = $clog2(BYTES_PER_BANK + 1);    // byte offset width
  localparam int unsigned SW    = ((OW > 16) ? OW : 16) + 1;     // offset + size

  // Pointer state
  logic          wr_bank_r, wr_bank_nxt;
  logic [OW-1:0] wr_off_r, wr_off_nxt;
  logic          rd_bank_r, rd_bank_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] cnt0_r, cnt0_nxt;
  logic [CW-1:0] cnt1_r, cnt1_nxt;

  // Pipeline registers
  logic                   s1_valid_r;
  pdstore_pkg::stage_t    s1_r, s1_nxt;
  pdstore_pkg::desc_t     rd_q_r;
  logic                   out_valid_r;
  pdstore_pkg::out_item_t out_r, out_nxt;

  pdstore_pkg::desc_t     mem [DEPTH];

  pdstore_pkg::in_item_t  req;
  logic                   in_fire, s1_adv;
  logic                   is_pop;

  // Push side
  logic          push_ok, wr_full, new_wb;
  logic [CW-1:0] wcnt, wcnt_other, base_cnt;
  logic [OW-1:0] base_off;
  logic [SW-1:0] off_sum;
  logic [10:0]   dropped;

  // Pop side
  logic          pop_flip, pop_bank, pop_ok;
  logic [CW-1:0] rcnt, rcnt_other, pop_idx, pop_cnt;

  // Memory ports
  logic               mem_we, mem_re;
  logic [AW-1:0]      waddr, raddr;
  pdstore_pkg::desc_t wdata;

  logic [CW-1:0] cnt_rd_nxt, cnt_other_nxt;

  assign req     = in_ch.payload;
  assign is_pop  = (req.operation == pdstore_pkg::OP_POP);
  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    // push checks and bank-full decision
    wcnt       = wr_bank_r ? cnt1_r : cnt0_r;
    wcnt_other = wr_bank_r ? cnt0_r : cnt1_r;
    push_ok    = (SW'(req.packet_size) <= SW'(BYTES_PER_BANK)) && req.has_compartment &&
                 (!req.is_receive ||
                  (req.has_header_size && req.has_interface && req.has_subinterface));
    off_sum    = SW'(wr_off_r) + SW'(req.packet_size);
    wr_full    = (wcnt >= CW'(PACKETS_PER_BANK)) || (off_sum >= SW'(BYTES_PER_BANK));
    new_wb     = wr_bank_r ^ wr_full;
    base_cnt   = wr_full ? '0 : wcnt;
    base_off   = wr_full ? '0 : wr_off_r;
    dropped    = wr_full ? 11'(wcnt_other) : '0;

    // pop: move to the other bank once the current one is used up
    rcnt       = rd_bank_r ? cnt1_r : cnt0_r;
    rcnt_other = rd_bank_r ? cnt0_r : cnt1_r;
    pop_flip   = (rcnt != '0) && (rd_idx_r == rcnt);
    pop_bank   = rd_bank_r ^ pop_flip;
    pop_idx    = pop_flip ? '0 : rd_idx_r;
    pop_cnt    = pop_flip ? rcnt_other : rcnt;
    pop_ok     = pop_idx < pop_cnt;

    waddr = new_wb ? (AW'(PACKETS_PER_BANK) + AW'(base_cnt)) : AW'(base_cnt);
    raddr = pop_bank ? (AW'(PACKETS_PER_BANK) + AW'(pop_idx)) : AW'(pop_idx);

    wdata.size        = req.packet_size;
    wdata.receive     = req.is_receive;
    wdata.compartment = req.compartment;
    wdata.if_idx      = req.has_interface ? req.interface_index : '0;
    wdata.sub_idx     = req.has_subinterface ? req.subinterface_index : '0;
    wdata.offset      = 16'(base_off);

    mem_we = in_fire && !is_pop && push_ok;
    mem_re = in_fire && is_pop && pop_ok;

    // next state: hold by default
    wr_bank_nxt = wr_bank_r;
    wr_off_nxt  = wr_off_r;
    rd_bank_nxt = rd_bank_r;
    rd_idx_nxt  = rd_idx_r;
    cnt0_nxt    = cnt0_r;
    cnt1_nxt    = cnt1_r;

    if (mem_we) begin
      wr_bank_nxt = new_wb;
      wr_off_nxt  = OW'(SW'(base_off) + SW'(req.packet_size));
      if (new_wb) begin
        cnt1_nxt = base_cnt + CW'(1);
      end else begin
        cnt0_nxt = base_cnt + CW'(1);
      end
      // read side leaves the bank being overwritten
      if (wr_full && (rd_bank_r == new_wb)) begin
        rd_bank_nxt = ~rd_bank_r;
        rd_idx_nxt  = '0;
      end
    end else if (in_fire && is_pop) begin
      rd_bank_nxt = pop_bank;
      rd_idx_nxt  = pop_ok ? (pop_idx + CW'(1)) : pop_idx;
    end

    cnt_rd_nxt    = rd_bank_nxt ? cnt1_nxt : cnt0_nxt;
    cnt_other_nxt = rd_bank_nxt ? cnt0_nxt : cnt1_nxt;

    s1_nxt.is_pop  = is_pop;
    s1_nxt.ok      = is_pop ? pop_ok : push_ok;
    s1_nxt.bank    = is_pop ? pop_bank : new_wb;
    s1_nxt.offset  = 16'(base_off);
    s1_nxt.dropped = dropped;
    s1_nxt.empty   = (rd_idx_nxt == cnt_rd_nxt) && (cnt_other_nxt == '0);
  end

  // Result assembly: pops take the registered memory read
  always_comb begin
    out_nxt             = '0;
    out_nxt.store_empty = s1_r.empty;
    if (s1_r.ok) begin
      out_nxt.accepted = 1'b1;
      out_nxt.bank     = s1_r.bank;
      if (s1_r.is_pop) begin
        out_nxt.data_offset      = rd_q_r.offset;
        out_nxt.out_size         = rd_q_r.size;
        out_nxt.out_receive      = rd_q_r.receive;
        out_nxt.out_compartment  = rd_q_r.compartment;
        out_nxt.out_interface    = rd_q_r.if_idx;
        out_nxt.out_subinterface = rd_q_r.sub_idx;
      end else begin
        out_nxt.data_offset   = s1_r.offset;
        out_nxt.dropped_count = s1_r.dropped;
      end
    end
  end

  // Descriptor memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[raddr];
    end
  end

  // Pointer state and stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_bank_r   <= 1'b0;
      wr_off_r    <= '0;
      rd_bank_r   <= 1'b0;
      rd_idx_r    <= '0;
      cnt0_r      <= '0;
      cnt1_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_bank_r <= wr_bank_nxt;
      wr_off_r  <= wr_off_nxt;
      rd_bank_r <= rd_bank_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cnt0_r    <= cnt0_nxt;
      cnt1_r    <= cnt1_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: advance with their stage, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // Bank counts never exceed a bank
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt0_r <= CW'(PACKETS_PER_BANK)) && (cnt1_r <= CW'(PACKETS_PER_BANK)))
    else $error("bank count beyond bank capacity");

  // Read index stays within the read bank's fill
  a_rd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= (rd_bank_r ? cnt1_r : cnt0_r))
    else $error("read index past read bank fill");

  // Write offset stays within the bank byte space
  a_wr_off: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(wr_off_r) <= SW'(BYTES_PER_BANK))
    else $error("write offset beyond bank bytes");

  // An accepted item always lands in the middle stage
  a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item lost before middle stage");

  // A stalled middle stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("middle stage changed while stalled");

endmodule

`default_nettype wire

@@ dv/two_bank_packet_descriptor_store_top_tb.sv @@
// Self-checking testbench for the two-bank packet descriptor store.
// Depends on pdstore_pkg and pdstore_chan_if; a small scoreboard class predicts
// every result item and checks the results as they leave the block.
`timescale 1ns / 1ps

module two_bank_packet_descriptor_store_top_tb;

  localparam int unsigned BANK_PKTS  = pdstore_pkg::DEF_PACKETS_PER_BANK;
  localparam int unsigned BANK_BYTES = pdstore_pkg::DEF_BYTES_PER_BANK;

  // One stored descriptor as the scoreboard keeps it.
  typedef struct packed {
    logic [15:0] size;
    logic        receive;
    logic [31:0] compartment;
    logic [31:0] if_idx;
    logic [31:0] sub_idx;
  } held_desc_t;

  // Mirror of the ping-pong store: bank fill counts, write and read pointers
  // and the descriptor slots, plus the queue of results still owed by the block.
  class desc_store_tracker;
    held_desc_t             slots [2*BANK_PKTS];
    int unsigned            fill [2];
    bit                     wr_bank;
    bit                     rd_bank;
    int unsigned            wr_offset;
    int unsigned            rd_index;
    int unsigned            rd_offset;
    pdstore_pkg::out_item_t results_due [$];
    int unsigned            errors;

    function new();
      fill      = '{0, 0};
      wr_bank   = 1'b0;
      rd_bank   = 1'b0;
      wr_offset = 0;
      rd_index  = 0;
      rd_offset = 0;
      errors    = 0;
    endfunction

    function bit is_drained();
      return rd_index == fill[rd_bank] && fill[!rd_bank] == 0;
    endfunction

    function pdstore_pkg::out_item_t predict_outcome(pdstore_pkg::in_item_t req);
      pdstore_pkg::out_item_t res;
      held_desc_t             d;
      int unsigned            slot;
      int unsigned            lost;
      res  = '0;
      lost = 0;
      if (req.operation == pdstore_pkg::OP_PUSH) begin
        if (req.has_compartment && req.packet_size <= BANK_BYTES &&
            (!req.is_receive ||
             (req.has_header_size && req.has_interface && req.has_subinterface))) begin
          // Full by count, or by bytes with >=: flip and overwrite the other bank.
          if (fill[wr_bank] >= BANK_PKTS || wr_offset + req.packet_size >= BANK_BYTES) begin
            wr_bank = !wr_bank;
            if (rd_bank == wr_bank) begin
              rd_bank   = !rd_bank;
              rd_index  = 0;
              rd_offset = 0;
            end
            lost           = fill[wr_bank];
            fill[wr_bank]  = 0;
            wr_offset      = 0;
          end
          slot          = (wr_bank ? BANK_PKTS : 0) + fill[wr_bank];
          d.size        = req.packet_size;
          d.receive     = req.is_receive;
          d.compartment = req.compartment;
          d.if_idx      = req.has_interface ? req.interface_index : '0;
          d.sub_idx     = req.has_subinterface ? req.subinterface_index : '0;
          slots[slot]   = d;
          res.accepted      = 1'b1;
          res.bank          = wr_bank;
          res.data_offset   = 16'(wr_offset);
          res.dropped_count = 11'(lost);
          fill[wr_bank]++;
          wr_offset += req.packet_size;
        end
      end else begin
        if (fill[rd_bank] != 0 && rd_index == fill[rd_bank]) begin
          rd_bank   = !rd_bank;
          rd_index  = 0;
          rd_offset = 0;
        end
        if (rd_index < fill[rd_bank]) begin
          d = slots[(rd_bank ? BANK_PKTS : 0) + rd_index];
          res.accepted         = 1'b1;
          res.bank             = rd_bank;
          res.data_offset      = 16'(rd_offset);
          res.out_size         = d.size;
          res.out_receive      = d.receive;
          res.out_compartment  = d.compartment;
          res.out_interface    = d.if_idx;
          res.out_subinterface = d.sub_idx;
          rd_offset += d.size;
          rd_index++;
        end
      end
      res.store_empty = is_drained();
      return res;
    endfunction

    function void note_request(pdstore_pkg::in_item_t req);
      results_due.push_back(predict_outcome(req));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pdstore_pkg::out_item_t got);
      pdstore_pkg::out_item_t want;
      if (results_due.size() == 0) begin
        $error("result item with nothing outstanding: 0x%0h", got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("bank", want.bank, got.bank);
      compare_field("data_offset", want.data_offset, got.data_offset);
      compare_field("out_size", want.out_size, got.out_size);
      compare_field("out_receive", want.out_receive, got.out_receive);
      compare_field("out_compartment", want.out_compartment, got.out_compartment);
      compare_field("out_interface", want.out_interface, got.out_interface);
      compare_field("out_subinterface", want.out_subinterface, got.out_subinterface);
      compare_field("dropped_count", want.dropped_count, got.dropped_count);
      compare_field("store_empty", want.store_empty, got.store_empty);
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  // Set during a stretch where neither side idles.
  bit   quiet = 1'b0;

  desc_store_tracker board = new();

  pdstore_chan_if #(.payload_t(pdstore_pkg::in_item_t))  in_ch ();
  pdstore_chan_if #(.payload_t(pdstore_pkg::out_item_t)) out_ch ();

  two_bank_packet_descriptor_store_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Result side: check every item taken at an edge, then pick the next ready.
  // Ready stays low through reset; afterwards it drops about a quarter of
  // the time unless the quiet stretch is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.payload);
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 25);
    end
  end

  // Any field, any flag, any operation.
  function automatic pdstore_pkg::in_item_t random_req();
    pdstore_pkg::in_item_t req;
    req.operation          = 1'($urandom);
    req.packet_size        = 16'($urandom);
    req.is_receive         = 1'($urandom);
    req.has_compartment    = 1'($urandom);
    req.has_header_size    = 1'($urandom);
    req.has_interface      = 1'($urandom);
    req.has_subinterface   = 1'($urandom);
    req.compartment        = $urandom;
    req.interface_index    = $urandom;
    req.subinterface_index = $urandom;
    return req;
  endfunction

  // Pop with random content in the fields it ignores.
  function automatic pdstore_pkg::in_item_t pop_req();
    pdstore_pkg::in_item_t req;
    req           = random_req();
    req.operation = pdstore_pkg::OP_POP;
    return req;
  endfunction

  // Push with chosen size and metadata flags, random identifiers.
  function automatic pdstore_pkg::in_item_t push_req(input logic [15:0] size, input logic rx,
                                                     input logic comp, input logic hdr,
                                                     input logic ifp, input logic subp);
    pdstore_pkg::in_item_t req;
    req                  = random_req();
    req.operation        = pdstore_pkg::OP_PUSH;
    req.packet_size      = size;
    req.is_receive       = rx;
    req.has_compartment  = comp;
    req.has_header_size  = hdr;
    req.has_interface    = ifp;
    req.has_subinterface = subp;
    return req;
  endfunction

  // Push that passes every check: a receive carries all its metadata,
  // a send keeps random header and index flags.
  function automatic pdstore_pkg::in_item_t good_push(input logic [15:0] size);
    pdstore_pkg::in_item_t req;
    req                 = random_req();
    req.operation       = pdstore_pkg::OP_PUSH;
    req.packet_size     = size;
    req.has_compartment = 1'b1;
    if (req.is_receive) begin
      req.has_header_size  = 1'b1;
      req.has_interface    = 1'b1;
      req.has_subinterface = 1'b1;
    end
    return req;
  endfunction

  // Offer one item, idling first at random, and hold it until the block takes it.
  task automatic send_request(input pdstore_pkg::in_item_t req);
    while (!quiet && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(req);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    pdstore_pkg::in_item_t req;
    int unsigned           stored;
    int unsigned           n;
    int unsigned           pick;

    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Pop with nothing stored.
    send_request(pop_req());
    // Each reason to reject a push: no compartment, then a receive missing
    // header size, interface or sub-interface.
    send_request(push_req(16'd100, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
    send_request(push_req(16'd100, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
    send_request(push_req(16'd100, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
    send_request(push_req(16'd100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    // Zero-size send without indices: the indices must come back as zero.
    req = push_req(16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    req.compartment        = '1;
    req.interface_index    = '1;
    req.subinterface_index = '1;
    send_request(req);
    // Largest receive packet; just fits since the byte test is >=.
    req = push_req(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    req.compartment        = '0;
    req.interface_index    = '1;
    req.subinterface_index = '0;
    send_request(req);
    send_request(pop_req());
    // Bank full by bytes: write side moves to bank 1, read side stays.
    send_request(push_req(16'd1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    // Full again: back onto bank 0, overwriting it while the read side is there,
    // so the read side follows to bank 1 and the old packets count as dropped.
    send_request(push_req(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
    repeat (4) send_request(pop_req());
    // Largest size but no compartment.
    send_request(push_req(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
    // Leave a fresh write bank holding one packet for the count-fill stretch.
    send_request(push_req(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    send_request(push_req(16'd1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));

    // Count fill: tiny packets so the bank runs out of descriptors well before
    // bytes, then a few more pushes past the flip. Sparse pops walk the read
    // side, sparse rejected pushes add noise. Start with neither side idling.
    quiet  = 1'b1;
    stored = 0;
    n      = 0;
    while (stored < BANK_PKTS + 6) begin
      if (n == 300) quiet = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_request(pop_req());
      end else if (pick < 9) begin
        req                 = random_req();
        req.operation       = pdstore_pkg::OP_PUSH;
        req.has_compartment = 1'b0;
        send_request(req);
      end else begin
        send_request(good_push(16'($urandom_range(0, 31))));
        stored++;
      end
      n++;
    end
    quiet = 1'b0;

    // Hold the sender until the block has answered everything.
    wait_for_drain();

    // Mixed traffic: sizes mostly modest, some up to the full range so the
    // byte limit trips often; pops heavy enough to cross banks and run dry.
    for (n = 0; n < 250; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_request(pop_req());
      end else if (pick < 50) begin
        req           = random_req();
        req.operation = pdstore_pkg::OP_PUSH;
        send_request(req);
      end else if ($urandom_range(0, 9) < 7) begin
        send_request(good_push(16'($urandom_range(0, 4095))));
      end else begin
        send_request(good_push(16'($urandom_range(0, 65535))));
      end
    end

    // Wind down: collect the last results, then leave the pipe idle so any
    // stray result still shows up as unexpected.
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS two_bank_packet_descriptor_store_top");
    end else begin
      $display("FAIL two_bank_packet_descriptor_store_top");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL two_bank_packet_descriptor_store_top");
    $finish;
  end

endmodule

@@ two_bank_packet_descriptor_store_top.f @@
src/pdstore_pkg.sv
src/pdstore_chan_if.sv
src/two_bank_packet_descriptor_store_top.sv
dv/two_bank_packet_descriptor_store_top_tb.sv
